// ===== sv/ngh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngh_pkg: shared constants for the noise gate
// Parameter defaults, register reset values and configuration register codes.
// ----------------------------------------------------------------------------
package ngh_pkg;

  // default sizing
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  // hold counter width is fixed
  localparam int HOLD_BITS = 19;

  // configuration write port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register reset values
  localparam int ENABLE_RST      = 1;
  localparam int OPEN_LEVEL_RST  = 59387;
  localparam int CLOSE_LEVEL_RST = 37470;
  localparam int HOLD_LENGTH_RST = 2160;
  localparam int CLOSED_GAIN_RST = 2072;
  localparam int ATTACK_RST      = 65263;
  localparam int RELEASE_RST     = 65525;

  // configuration register codes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE       = 3'd0,
    REG_OPEN_LEVEL   = 3'd1,
    REG_CLOSE_LEVEL  = 3'd2,
    REG_HOLD_LENGTH  = 3'd3,
    REG_CLOSED_GAIN  = 3'd4,
    REG_ATTACK_COEF  = 3'd5,
    REG_RELEASE_COEF = 3'd6
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== sv/ngh_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngh interfaces: valid/ready channels of the noise gate
// Sample request channel, gated result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ngh_in_if #(
  parameter int CH_BITS     = 1,
  parameter int SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CH_BITS-1:0]            channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface ngh_out_if #(
  parameter int SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          is_open;

  modport source (output valid, output sample_out, output is_open, input ready);
  modport sink   (input valid, input sample_out, input is_open, output ready);
endinterface

interface ngh_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ngh_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [ngh_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ngh_state_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngh_state_mem: per-channel state memory
// One write port, one registered read port; entries never written since reset
// read back as the reset word, tracked by one valid bit per entry.
// ----------------------------------------------------------------------------
module ngh_state_mem #(
  parameter int               DEPTH      = ngh_pkg::CHANNELS_DEF,
  parameter int               ADDR_BITS  = 1,
  parameter int               WIDTH      = 8,
  parameter logic [WIDTH-1:0] RESET_WORD = '0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output      logic [WIDTH-1:0]     rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // written-since-reset flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read, unwritten entries give the reset word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : RESET_WORD;
    end
  end

  assign rd_data = rd_data_r;

  // the sequencer never reads and writes back in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("state memory read and write in the same cycle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (int'(wr_addr) < DEPTH))
    else $error("state memory write beyond depth");

endmodule
`default_nettype wire

// ===== sv/noise_gate_hysteresis_hold_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noise_gate_hysteresis_hold_unit: multichannel audio noise gate
// Peak envelope, open/close hysteresis with hold, smoothed gain, saturated
// output. Per-channel state sits in a small state memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_req   : one request per sample, carrying channel and signed sample_in.
//              The channel number is taken modulo CHANNELS.
//   out_rsp  : exactly one result per request, in order: sample_out, is_open.
//   cfg_wr   : register writes (index, data), always ready; write only while
//              no request is in flight.
// Sequence:
//   An enabled sample passes the envelope, level, gain, gain sum, output
//   scaling and final steps; a disabled gate goes from the envelope step to
//   the final step. The steps follow the single shared multiplier, used
//   three times per enabled sample (envelope glide, gain glide, output
//   scaling); each glide is followed by an add. The state memory read is
//   registered; the result is registered in the final step, and the next
//   request is accepted only after it and any write-back of the state.
// Reset: rst_n (synchronous) restores register defaults, clears the state
//   valid bits (envelope 0, closed, hold 0, unity gain) and empties the
//   output register. No clearing pass is needed.
// Stall: a result waits in the output register; the next request is still
//   taken and processed, and its result waits in the final step until the
//   output register frees up.
// ----------------------------------------------------------------------------
module noise_gate_hysteresis_hold_unit #(
  parameter int CHANNELS    = ngh_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = ngh_pkg::COEF_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ngh_in_if.sink     in_req,
  ngh_out_if.source  out_rsp,
  ngh_cfg_if.sink    cfg_wr
);

  localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EB      = SAMPLE_BITS - 1;              // envelope / level width
  localparam int GB      = COEF_BITS + 1;                // gain width
  localparam int HB      = ngh_pkg::HOLD_BITS;
  localparam int MA      = (SAMPLE_BITS > COEF_BITS + 2) ? SAMPLE_BITS : COEF_BITS + 2;
  localparam int MB      = COEF_BITS + 2;
  localparam int PW      = MA + MB;
  localparam int W       = EB + 1 + HB + GB;

  localparam logic [GB-1:0] GAIN_ONE = {1'b1, {COEF_BITS{1'b0}}};
  localparam logic [W-1:0]  ENT_RST  = {{EB{1'b0}}, 1'b0, {HB{1'b0}}, GAIN_ONE};
  localparam logic signed [PW-1:0] Y_MAX =
    $signed({{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [PW-1:0] Y_MIN =
    $signed({{(PW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

  typedef struct packed {
    logic [EB-1:0] env;
    logic          open;
    logic [HB-1:0] hold;
    logic [GB-1:0] gain;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ENV, S_LVL, S_GAIN, S_GSUM, S_SMUL, S_DONE
  } state_t;

  // configuration registers
  logic                 enable_r;
  logic [EB-1:0]        open_level_r;
  logic [EB-1:0]        close_level_r;
  logic [HB-1:0]        hold_length_r;
  logic [GB-1:0]        closed_gain_r;
  logic [COEF_BITS-1:0] attack_r;
  logic [COEF_BITS-1:0] release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'(ngh_pkg::ENABLE_RST);
      open_level_r  <= EB'(ngh_pkg::OPEN_LEVEL_RST);
      close_level_r <= EB'(ngh_pkg::CLOSE_LEVEL_RST);
      hold_length_r <= HB'(ngh_pkg::HOLD_LENGTH_RST);
      closed_gain_r <= GB'(ngh_pkg::CLOSED_GAIN_RST);
      attack_r      <= COEF_BITS'(ngh_pkg::ATTACK_RST);
      release_r     <= COEF_BITS'(ngh_pkg::RELEASE_RST);
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (ngh_pkg::reg_idx_t'(cfg_wr.index))
        ngh_pkg::REG_ENABLE:       enable_r      <= cfg_wr.data[0];
        ngh_pkg::REG_OPEN_LEVEL:   open_level_r  <= cfg_wr.data[EB-1:0];
        ngh_pkg::REG_CLOSE_LEVEL:  close_level_r <= cfg_wr.data[EB-1:0];
        ngh_pkg::REG_HOLD_LENGTH:  hold_length_r <= cfg_wr.data[HB-1:0];
        ngh_pkg::REG_CLOSED_GAIN:  closed_gain_r <= cfg_wr.data[GB-1:0];
        ngh_pkg::REG_ATTACK_COEF:  attack_r      <= cfg_wr.data[COEF_BITS-1:0];
        ngh_pkg::REG_RELEASE_COEF: release_r     <= cfg_wr.data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  // sequencer and datapath registers
  state_t                        state_r;
  logic [CH_BITS-1:0]            ch_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic                          bypass_r;
  logic signed [PW-1:0]          prod_r;
  logic [EB-1:0]                 env_r;
  logic                          open_r;
  logic [HB-1:0]                 hold_r;
  logic [GB-1:0]                 gain_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_open_r;

  logic                 in_acc;
  logic [CH_BITS-1:0]   ch_mod;
  logic [W-1:0]         rd_word;
  ent_t                 cur;
  ent_t                 wr_ent;
  logic                 wr_en;
  logic                 out_load;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  // channel modulo CHANNELS: one compare and subtract suffices
  assign ch_mod = (int'(in_req.channel) >= CHANNELS) ?
                  (in_req.channel - CH_BITS'(CHANNELS)) : in_req.channel;

  ngh_state_mem #(
    .DEPTH      (CHANNELS),
    .ADDR_BITS  (CH_BITS),
    .WIDTH      (W),
    .RESET_WORD (ENT_RST)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (ch_mod),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (ch_r),
    .wr_data (wr_ent)
  );

  assign cur = ent_t'(rd_word);

  // sample magnitude, most negative value saturates
  logic [SAMPLE_BITS-1:0] abs_full;
  logic [EB-1:0]          mag;
  assign abs_full = smp_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_r) : SAMPLE_BITS'(smp_r);
  assign mag      = abs_full[SAMPLE_BITS-1] ? {EB{1'b1}} : abs_full[EB-1:0];

  // envelope glide operands: c*env + (1-c)*mag = mag + c*(env - mag)
  logic [COEF_BITS-1:0]          env_coef;
  logic signed [SAMPLE_BITS-1:0] env_diff;
  assign env_coef = (mag > cur.env) ? attack_r : release_r;
  assign env_diff = $signed({1'b0, cur.env}) - $signed({1'b0, mag});

  // gain target and glide operands
  logic [GB-1:0]        closed_tgt;
  logic [GB-1:0]        target;
  logic [COEF_BITS-1:0] gain_coef;
  logic signed [GB:0]   gain_diff;
  assign closed_tgt = (closed_gain_r > GAIN_ONE) ? GAIN_ONE : closed_gain_r;
  assign target     = open_r ? GAIN_ONE : closed_tgt;
  assign gain_coef  = (target < cur.gain) ? attack_r : release_r;
  assign gain_diff  = $signed({1'b0, cur.gain}) - $signed({1'b0, target});

  // shared multiplier operand select
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;
  logic signed [PW-1:0] mult;

  always_comb begin
    case (state_r)
      S_ENV: begin
        op_a = MA'(env_diff);
        op_b = $signed({2'b00, env_coef});
      end
      S_GAIN: begin
        op_a = MA'(gain_diff);
        op_b = $signed({2'b00, gain_coef});
      end
      S_SMUL: begin
        op_a = MA'(smp_r);
        op_b = $signed({1'b0, gain_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mult = op_a * op_b;

  // glide sums, always non-negative
  logic signed [PW-1:0] env_sum;
  logic signed [PW-1:0] gain_sum;
  logic [EB-1:0]        env_new;
  logic [GB-1:0]        gain_new;
  assign env_sum  = $signed(PW'({mag, {COEF_BITS{1'b0}}})) + prod_r;
  assign env_new  = env_sum[COEF_BITS +: EB];
  assign gain_sum = $signed(PW'({target, {COEF_BITS{1'b0}}})) + prod_r;
  assign gain_new = gain_sum[COEF_BITS +: GB];

  // output scaling: floor shift, then saturate
  logic signed [PW-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  assign y_full = prod_r >>> COEF_BITS;
  assign y_sat  = (y_full > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
                  (y_full < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] :
                  y_full[SAMPLE_BITS-1:0];

  // write-back of the updated channel state
  assign wr_en  = (state_r == S_GSUM);
  assign wr_ent = '{env: env_r, open: open_r, hold: hold_r, gain: gain_new};

  // final step hands its result to a free or draining output register
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load from the final step, else drain on handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ch_r     <= ch_mod;
            smp_r    <= in_req.sample_in;
            bypass_r <= !enable_r;
            state_r  <= S_ENV;
          end
        end
        S_ENV: begin
          prod_r  <= mult;
          state_r <= bypass_r ? S_DONE : S_LVL;
        end
        S_LVL: begin
          // hysteresis: open test first, then close test with hold
          env_r <= env_new;
          if (env_new >= open_level_r) begin
            open_r <= 1'b1;
            hold_r <= hold_length_r;
          end else if (env_new < close_level_r) begin
            if (cur.hold != '0) begin
              open_r <= cur.open;
              hold_r <= cur.hold - HB'(1);
            end else begin
              open_r <= 1'b0;
              hold_r <= cur.hold;
            end
          end else begin
            open_r <= cur.open;
            hold_r <= cur.hold;
          end
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          prod_r  <= mult;
          state_r <= S_GSUM;
        end
        S_GSUM: begin
          gain_r  <= gain_new;
          state_r <= S_SMUL;
        end
        S_SMUL: begin
          prod_r  <= mult;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_sample_r <= bypass_r ? smp_r : y_sat;
            out_open_r   <= bypass_r ? cur.open : open_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.sample_out = out_sample_r;
  assign out_rsp.is_open    = out_open_r;

  // a result appears only from the final step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the final step");

  // smoothed gain never passes unity
  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SMUL) |-> (gain_r <= GAIN_ONE))
    else $error("smoothed gain above unity");

  // accepted channel is folded into range
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (int'(ch_r) < CHANNELS))
    else $error("channel index out of range");

  // an enabled request reaches the final step only through output scaling
  a_done_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !bypass_r) |->
      ($past(state_r) == S_SMUL || $past(state_r) == S_DONE))
    else $error("final step entered without output scaling");

endmodule
`default_nettype wire

// ===== tb/sv/ngh_gate_board_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngh_gate_board_pkg: gated sample scoreboard for the noise gate bench
// Tracks the register settings and per-channel gate state, works out the
// gated sample for every accepted request and checks returned results in order.
// ----------------------------------------------------------------------------
package ngh_gate_board_pkg;
  import ngh_pkg::*;

  localparam int    SW       = SAMPLE_BITS_DEF;
  localparam int    CW       = COEF_BITS_DEF;
  localparam int    NCH      = CHANNELS_DEF;
  localparam longint ENV_MAX  = (longint'(1) << (SW - 1)) - 1;
  localparam longint GAIN_ONE = longint'(1) << CW;
  localparam longint SMP_MIN  = -ENV_MAX - 1;

  typedef struct {
    logic signed [SW-1:0] sample_out;
    logic                 is_open;
  } gated_t;

  class gated_sample_board;
    // register copy
    bit              gate_on;
    bit [SW-2:0]     open_lvl;
    bit [SW-2:0]     close_lvl;
    bit [HOLD_BITS-1:0] hold_len;
    bit [CW:0]       closed_gain;
    bit [CW-1:0]     attack;
    bit [CW-1:0]     rel;

    // per-channel gate state
    bit [SW-2:0]     envelope [NCH];
    bit              open_flag [NCH];
    bit [HOLD_BITS-1:0] hold_count [NCH];
    bit [CW:0]       gain [NCH];

    gated_t          gated_due [$];
    int              mismatches;

    function new();
      gate_on     = ENABLE_RST[0];
      open_lvl    = (SW-1)'(OPEN_LEVEL_RST);
      close_lvl   = (SW-1)'(CLOSE_LEVEL_RST);
      hold_len    = HOLD_BITS'(HOLD_LENGTH_RST);
      closed_gain = (CW+1)'(CLOSED_GAIN_RST);
      attack      = CW'(ATTACK_RST);
      rel         = CW'(RELEASE_RST);
      for (int k = 0; k < NCH; k++) begin
        envelope[k]   = '0;
        open_flag[k]  = 1'b0;
        hold_count[k] = '0;
        gain[k]       = (CW+1)'(GAIN_ONE);
      end
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_ENABLE:       gate_on     = data[0];
        REG_OPEN_LEVEL:   open_lvl    = data[SW-2:0];
        REG_CLOSE_LEVEL:  close_lvl   = data[SW-2:0];
        REG_HOLD_LENGTH:  hold_len    = data[HOLD_BITS-1:0];
        REG_CLOSED_GAIN:  closed_gain = data[CW:0];
        REG_ATTACK_COEF:  attack      = data[CW-1:0];
        REG_RELEASE_COEF: rel         = data[CW-1:0];
        default: ;
      endcase
    endfunction

    // one-pole step from cur toward tgt
    function longint glide(longint coef, longint cur, longint tgt);
      return (coef * cur + (GAIN_ONE - coef) * tgt) >> CW;
    endfunction

    // accepted request: advance the channel state and queue the gated sample
    function void note_sample(bit ch, logic signed [SW-1:0] s);
      longint smp, mag, c, tgt, y;
      gated_t r;
      smp = s;
      if (!gate_on) begin
        // bypass: sample unchanged, state untouched
        r.sample_out = s;
        r.is_open    = open_flag[ch];
        gated_due.push_back(r);
        return;
      end
      mag = (smp < 0) ? -smp : smp;
      if (mag > ENV_MAX) mag = ENV_MAX;
      c = (mag > longint'(envelope[ch])) ? longint'(attack) : longint'(rel);
      envelope[ch] = (SW-1)'(glide(c, longint'(envelope[ch]), mag));

      // hysteresis with hold; open test first
      if (envelope[ch] >= open_lvl) begin
        open_flag[ch]  = 1'b1;
        hold_count[ch] = hold_len;
      end else if (envelope[ch] < close_lvl) begin
        if (hold_count[ch] != 0) hold_count[ch] = hold_count[ch] - 1'b1;
        else open_flag[ch] = 1'b0;
      end

      // closed gain saturates at unity
      if (open_flag[ch]) tgt = GAIN_ONE;
      else tgt = (longint'(closed_gain) > GAIN_ONE) ? GAIN_ONE : longint'(closed_gain);
      c = (tgt < longint'(gain[ch])) ? longint'(attack) : longint'(rel);
      gain[ch] = (CW+1)'(glide(c, longint'(gain[ch]), tgt));

      // floor scaling, then clamp to sample range
      y = (smp * longint'(gain[ch])) >>> CW;
      if (y > ENV_MAX) y = ENV_MAX;
      if (y < SMP_MIN) y = SMP_MIN;
      r.sample_out = SW'(y);
      r.is_open    = open_flag[ch];
      gated_due.push_back(r);
    endfunction

    function void check_gated(logic signed [SW-1:0] got_sample, logic got_open);
      gated_t want;
      if (gated_due.size() == 0) begin
        $error("result with no request pending: sample_out=%0d is_open=%0b",
               got_sample, got_open);
        mismatches++;
        return;
      end
      want = gated_due.pop_front();
      if (got_sample !== want.sample_out) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want.sample_out, got_sample);
        mismatches++;
      end
      if (got_open !== want.is_open) begin
        $error("is_open mismatch: expected %0b, actual %0b", want.is_open, got_open);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_noise_gate_hysteresis_hold_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_noise_gate_hysteresis_hold_unit: self-checking bench for the noise gate
// Directed samples and register settings, then loud/quiet bursts per channel
// under random sender gaps and receiver stalls; every result is checked
// against the scoreboard's gated sample in order.
// ----------------------------------------------------------------------------
module tb_noise_gate_hysteresis_hold_unit;
  import ngh_pkg::*;
  import ngh_gate_board_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 80;
  localparam int SETTLE      = 10;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_MAX    = (1 << HOLD_BITS) - 1;
  localparam int ENV_TOP     = int'(ENV_MAX);
  localparam int GAIN_UNITY  = int'(GAIN_ONE);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ngh_in_if  #(.CH_BITS(1), .SAMPLE_BITS(SW)) in_req ();
  ngh_out_if #(.SAMPLE_BITS(SW))              out_rsp ();
  ngh_cfg_if                                  cfg_wr ();

  noise_gate_hysteresis_hold_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  gated_sample_board board;
  bit  loud [NCH];
  int  long_hold_asks = 0;
  int  long_hold_done = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  int rx_hold_left = 0;
  int rx_mode      = 0;
  int rx_span      = 0;
  int rx_tick      = 0;
  initial out_rsp.ready = 1'b0;
  always @(posedge clk) begin
    rx_tick++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_rsp.ready <= 1'b0;
    end else if (long_hold_asks != long_hold_done) begin
      long_hold_done++;
      rx_hold_left = LONG_HOLD;
      out_rsp.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(20, 150);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        0:       out_rsp.ready <= 1'b1;
        1:       out_rsp.ready <= ($urandom_range(0, 1) == 0);
        2:       out_rsp.ready <= (rx_tick % 4 == 0);
        default: out_rsp.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      board.check_gated(out_rsp.sample_out, out_rsp.is_open);
  end

  // watchdog on cycles with no handshake at all
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request; valid stays high afterwards so a following request can go back to back
  task automatic send_sample(bit ch, logic signed [SW-1:0] s);
    in_req.valid     <= 1'b1;
    in_req.channel   <= ch;
    in_req.sample_in <= s;
    do @(posedge clk); while (!in_req.ready);
    board.note_sample(ch, s);
  endtask

  task automatic idle_sender(int cycles);
    in_req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every result is back and the last write-back is done
  task automatic settle();
    in_req.valid <= 1'b0;
    while (board.gated_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    board.set_reg(idx, data);
  endtask

  task automatic apply_setting(int en, int open_lvl, int close_lvl, int hold_len,
                               int closed_gain, int att, int rel);
    write_reg(REG_ENABLE, en);
    write_reg(REG_OPEN_LEVEL, open_lvl);
    write_reg(REG_CLOSE_LEVEL, close_lvl);
    write_reg(REG_HOLD_LENGTH, hold_len);
    write_reg(REG_CLOSED_GAIN, closed_gain);
    write_reg(REG_ATTACK_COEF, att);
    write_reg(REG_RELEASE_COEF, rel);
    cfg_wr.valid <= 1'b0;
  endtask

  // bursts of requests; each channel alternates loud and quiet stretches,
  // with some full-range noise mixed in
  task automatic send_phase(int count);
    int sent, burst, gap;
    bit ch, neg;
    longint mag;
    logic signed [SW-1:0] s;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && sent < count; j++) begin
        ch = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 23) == 0) loud[ch] = !loud[ch];
        if ($urandom_range(0, 9) == 0) begin
          s = SW'($urandom);
        end else begin
          if (loud[ch]) mag = $urandom_range(ENV_TOP, 32'(board.open_lvl));
          else mag = $urandom_range(0, 32'(board.close_lvl / 2));
          neg = 1'($urandom_range(0, 1));
          s = neg ? SW'(-mag) : SW'(mag);
        end
        send_sample(ch, s);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) idle_sender(gap);
    end
  endtask

  initial begin
    board            = new();
    in_req.valid     = 1'b0;
    in_req.channel   = '0;
    in_req.sample_in = '0;
    cfg_wr.valid     = 1'b0;
    cfg_wr.index     = REG_ENABLE;
    cfg_wr.data      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full-scale, most negative, zero and tiny samples
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b1, -24'sd8388608);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b1, -24'sd1);
    send_sample(1'b0, 24'sd1);
    settle();

    // instant envelope, short hold, closed gain above unity
    apply_setting(1, 1000, 500, 2, 100000, 0, 0);
    send_sample(1'b0, 24'sd5000);
    send_sample(1'b0, -24'sd5000);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b1, -24'sd8388608);
    send_sample(1'b1, 24'sd700);
    settle();

    // gate disabled
    apply_setting(0, 1000, 500, 2, 100000, 0, 0);
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b1, -24'sd8388608);
    send_sample(1'b0, 24'sd12345);
    settle();

    // close level above open level
    apply_setting(1, 100, 2000, 0, 0, 0, 0);
    send_sample(1'b0, 24'sd50);
    send_sample(1'b0, 24'sd150);
    send_sample(1'b0, 24'sd50);
    send_sample(1'b1, 24'sd3000);
    settle();

    // random phases: gate disabled first, then extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(0, $urandom_range(1000, 200000), $urandom_range(0, 1000),
                         $urandom_range(0, 12), $urandom_range(0, 65536),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
        1: apply_setting(1, ENV_TOP, 0, HOLD_MAX, 0, 65535, 65535);
        2: apply_setting(1, 0, ENV_TOP, 0, GAIN_UNITY, 0, 0);
        3: apply_setting(1, ENV_TOP, ENV_TOP, HOLD_MAX, (1 << (CW + 1)) - 1, 0, 65535);
        default: begin
          int o;
          o = $urandom_range(1000, 2000000);
          apply_setting(1, o,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(o, ENV_TOP)
                                                    : $urandom_range(0, o),
                        $urandom_range(0, 12), $urandom_range(0, 65536),
                        $urandom_range(0, 60000), $urandom_range(0, 50000));
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 4) long_hold_asks++;
      send_phase(PHASE_ITEMS);
      settle();
    end

    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.gated_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ngh_pkg.sv
sv/ngh_ifs.sv
sv/ngh_state_mem.sv
sv/noise_gate_hysteresis_hold_unit.sv
tb/sv/ngh_gate_board_pkg.sv
tb/sv/tb_noise_gate_hysteresis_hold_unit.sv
